/* src/assert_macros.svh */
// Assertion macros used by the core RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define AST_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/aesbe_pkg.sv */
// Shared types, tables and round functions for the AES block encryptor
`timescale 1ns / 1ps
package aesbe_pkg;

  localparam int unsigned MaxRoundsDefault = 14;
  localparam int unsigned KeyBits          = 256;

  typedef enum logic [2:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_KEYSIZE = 3'd4,
    REG_CHAIN   = 3'd5,
    REG_IV_HI   = 3'd6,
    REG_IV_LO   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic start;
    logic step;
  } ks_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [11] = '{
    8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte n of the state sits at bits 127-8n down
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32*c -: 8];
      a1  = s[119 - 32*c -: 8];
      a2  = s[111 - 32*c -: 8];
      a3  = s[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

endpackage

/* src/aesbe_key_sched.sv */
// Key schedule: produces one expanded key word per step
`timescale 1ns / 1ps
module aesbe_key_sched #(
  parameter int unsigned MAX_ROUNDS = aesbe_pkg::MaxRoundsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  aesbe_pkg::ks_ctrl_t            ctrl_i,
  input  logic [aesbe_pkg::KeyBits-1:0]  key_i,
  input  logic [1:0]                     key_size_i,
  output logic [127:0]                   round_key_o
);

  localparam int unsigned RconW = $clog2(MAX_ROUNDS + 2);

  logic [31:0]      win_q [8];
  logic [2:0]       kpos_q, kpos_d;
  logic [RconW-1:0] ridx_q, ridx_d;
  logic [1:0]       code;
  logic [2:0]       nk_m1;
  logic [31:0]      t, w_new;
  logic [RconW-1:0] rmod;

  assign code  = (key_size_i == 2'd3) ? 2'd2 : key_size_i;
  assign nk_m1 = 3'd3 + {code, 1'b0};
  assign rmod  = (ridx_q >= RconW'(11)) ? ridx_q - RconW'(11) : ridx_q;

  always_comb begin
    kpos_d = ctrl_i.start ? '0 : kpos_q;
    ridx_d = ctrl_i.start ? '0 : ridx_q;
    t      = win_q[0];
    if (ridx_q == '0) begin
      w_new = key_i[aesbe_pkg::KeyBits - 1 - 32*kpos_q -: 32];
    end else begin
      if (kpos_q == '0) begin
        t = aesbe_pkg::sub_word({t[23:0], t[31:24]}) ^ {aesbe_pkg::RCON[rmod[3:0]], 24'h0};
      end else if (code == 2'd2 && kpos_q == 3'd4) begin
        t = aesbe_pkg::sub_word(t);
      end
      w_new = win_q[nk_m1] ^ t;
    end
    if (ctrl_i.step) begin
      if (kpos_q == nk_m1) begin
        kpos_d = '0;
        ridx_d = ridx_q + RconW'(1);
      end else begin
        kpos_d = kpos_q + 3'd1;
      end
    end
  end

  assign round_key_o = {win_q[2], win_q[1], win_q[0], w_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kpos_q <= '0;
      ridx_q <= '0;
    end else begin
      kpos_q <= kpos_d;
      ridx_q <= ridx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      win_q[0] <= w_new;
      for (int k = 1; k < 8; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

endmodule

/* src/aes_block_encrypt_ecb_cbc_core.sv */
// AES-128/192/256 block encryptor, ECB or CBC, top level
// One block at a time: a new input is accepted only while idle, after the last
//   result is registered; the key schedule makes one 32-bit word per cycle
//   unless the final round is held, and the round unit fires once per four words.
// Reset: config registers and the chaining block clear to zero; no result pending.
// Result is held in an output register until its transaction completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aes_block_encrypt_ecb_cbc_core #(
  parameter int unsigned MAX_ROUNDS = aesbe_pkg::MaxRoundsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        message_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

  localparam int unsigned RndW = $clog2(MAX_ROUNDS + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  // configuration
  logic [63:0]  key_q [4];
  logic [1:0]   key_size_q;
  logic         chain_mode_q;
  logic [63:0]  iv_hi_q, iv_lo_q;

  // datapath and sequencer
  state_e        state_q;
  logic [127:0]  blk_q, chain_q;
  logic [1:0]    wsub_q;
  logic [RndW-1:0] rnd_q, nr;
  logic          out_valid_q;
  logic [63:0]   c_hi_q, c_lo_q;

  logic          accept, last, fire, round_tick;
  logic [127:0]  rk, in_blk, blk_next, sbs;
  logic [1:0]    code;
  logic [4:0]    nr_full;
  aesbe_pkg::ks_ctrl_t ks_ctrl;

  assign code    = (key_size_q == 2'd3) ? 2'd2 : key_size_q;
  assign nr_full = 5'd10 + {2'b0, code, 1'b0};
  assign nr      = (nr_full > 5'(MAX_ROUNDS)) ? RndW'(MAX_ROUNDS) : RndW'(nr_full);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (state_q == ST_RUN) && (wsub_q == 2'd3) && (rnd_q == nr);
  // hold the final round while the previous result is still unread
  assign fire       = (state_q == ST_RUN) && !(last && out_valid_q && !out_ready_i);
  assign round_tick = fire && (wsub_q == 2'd3);

  assign ks_ctrl.start = accept;
  assign ks_ctrl.step  = fire;

  aesbe_key_sched #(.MAX_ROUNDS(MAX_ROUNDS)) u_ks (
    .clk_i,
    .rst_ni,
    .ctrl_i      (ks_ctrl),
    .key_i       ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_size_i  (key_size_q),
    .round_key_o (rk)
  );

  // CBC whitening on entry: IV for a message start, else last ciphertext
  always_comb begin
    in_blk = {plain_high_i, plain_low_i};
    if (chain_mode_q) begin
      in_blk = in_blk ^ (message_start_i ? {iv_hi_q, iv_lo_q} : chain_q);
    end
  end

  // the one shared round unit
  always_comb begin
    sbs = aesbe_pkg::sub_shift(blk_q);
    if (rnd_q == '0) begin
      blk_next = blk_q ^ rk;
    end else if (rnd_q == nr) begin
      blk_next = sbs ^ rk;
    end else begin
      blk_next = aesbe_pkg::mix_columns(sbs) ^ rk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) key_q[k] <= '0;
      key_size_q   <= '0;
      chain_mode_q <= 1'b0;
      iv_hi_q      <= '0;
      iv_lo_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (aesbe_pkg::reg_idx_e'(cfg_idx_i))
        aesbe_pkg::REG_KEY0:    key_q[0]     <= cfg_data_i;
        aesbe_pkg::REG_KEY1:    key_q[1]     <= cfg_data_i;
        aesbe_pkg::REG_KEY2:    key_q[2]     <= cfg_data_i;
        aesbe_pkg::REG_KEY3:    key_q[3]     <= cfg_data_i;
        aesbe_pkg::REG_KEYSIZE: key_size_q   <= cfg_data_i[1:0];
        aesbe_pkg::REG_CHAIN:   chain_mode_q <= cfg_data_i[0];
        aesbe_pkg::REG_IV_HI:   iv_hi_q      <= cfg_data_i;
        aesbe_pkg::REG_IV_LO:   iv_lo_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wsub_q      <= '0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
      blk_q       <= '0;
      c_hi_q      <= '0;
      c_lo_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            blk_q   <= in_blk;
            wsub_q  <= '0;
            rnd_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fire) begin
            wsub_q <= wsub_q + 2'd1;
          end
          if (round_tick) begin
            blk_q <= blk_next;
            rnd_q <= rnd_q + RndW'(1);
            if (last) begin
              chain_q     <= blk_next;
              c_hi_q      <= blk_next[127:64];
              c_lo_q      <= blk_next[63:0];
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_high_o = c_hi_q;
  assign cipher_low_o  = c_lo_q;

  `AST_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o)
  `AST_NEXT(a_result_on_last, clk_i, rst_ni, last && fire, out_valid_o && in_ready_o)
  `AST_IMPLIES(a_round_bound, clk_i, rst_ni, state_q == ST_RUN, rnd_q <= nr)

endmodule

/* tb/sv/aes_block_encrypt_ecb_cbc_checker.sv */
// Checker: snoops config and both channels, predicts each ciphertext and compares
`timescale 1ns / 1ps
module aes_block_encrypt_ecb_cbc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        message_start_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  output int          errors_o,
  output int          pending_o
);

  logic [63:0]  key_q [4];
  logic [1:0]   ksize_q;
  logic         cbc_q;
  logic [127:0] iv_q;
  logic [127:0] last_cipher;
  logic [127:0] rkey [15];
  int unsigned  nrounds;
  logic [127:0] cipher_q [$];

  function automatic logic [31:0] sbox4(input logic [31:0] w);
    return {aesbe_pkg::SBOX[w[31:24]], aesbe_pkg::SBOX[w[23:16]],
            aesbe_pkg::SBOX[w[15:8]], aesbe_pkg::SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void expand_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    int unsigned code, nk, total;
    code = (ksize_q == 2'd3) ? 2 : ksize_q;
    nk = 4 + 2 * code;
    nrounds = 10 + 2 * code;
    if (nrounds > 14) nrounds = 14;
    for (int i = 0; i < nk; i++) w[i] = (i % 2) ? key_q[i/2][31:0] : key_q[i/2][63:32];
    total = 4 * (nrounds + 1);
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0)
        t = sbox4({t[23:0], t[31:24]}) ^ {aesbe_pkg::RCON[(i/nk) % 11], 24'h0};
      else if (nk > 6 && i % nk == 4) t = sbox4(t);
      w[i] = w[i-nk] ^ t;
    end
    for (int r = 0; r < 15; r++)
      rkey[r] = (r <= nrounds) ? {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]} : '0;
  endfunction

  // byte n of the state sits at bits 127-8n down
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [127:0] s, t;
    logic [7:0] a0, a1, a2, a3, x;
    s = blk ^ rkey[0];
    for (int rnd = 1; rnd <= nrounds; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127 - 8*(r + 4*c) -: 8] = aesbe_pkg::SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
      s = t;
      if (rnd < nrounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[127 - 32*c -: 8]; a1 = s[119 - 32*c -: 8];
          a2 = s[111 - 32*c -: 8]; a3 = s[103 - 32*c -: 8];
          x  = a0 ^ a1 ^ a2 ^ a3;
          t[127 - 32*c -: 8] = a0 ^ x ^ dbl(a0 ^ a1);
          t[119 - 32*c -: 8] = a1 ^ x ^ dbl(a1 ^ a2);
          t[111 - 32*c -: 8] = a2 ^ x ^ dbl(a2 ^ a3);
          t[103 - 32*c -: 8] = a3 ^ x ^ dbl(a3 ^ a0);
        end
        s = t;
      end
      s = s ^ rkey[rnd];
    end
    return s;
  endfunction

  assign pending_o = cipher_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] blk, want;
    int bad;
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      ksize_q = '0;
      cbc_q = 1'b0;
      iv_q = '0;
      last_cipher = '0;
      cipher_q.delete();
      errors_o <= 0;
      expand_keys();
    end else begin
      bad = 0;
      if (cfg_we_i) begin
        case (aesbe_pkg::reg_idx_e'(cfg_idx_i))
          aesbe_pkg::REG_KEY0:    key_q[0] = cfg_data_i;
          aesbe_pkg::REG_KEY1:    key_q[1] = cfg_data_i;
          aesbe_pkg::REG_KEY2:    key_q[2] = cfg_data_i;
          aesbe_pkg::REG_KEY3:    key_q[3] = cfg_data_i;
          aesbe_pkg::REG_KEYSIZE: ksize_q = cfg_data_i[1:0];
          aesbe_pkg::REG_CHAIN:   cbc_q = cfg_data_i[0];
          aesbe_pkg::REG_IV_HI:   iv_q[127:64] = cfg_data_i;
          aesbe_pkg::REG_IV_LO:   iv_q[63:0] = cfg_data_i;
          default: ;
        endcase
        expand_keys();
      end
      if (in_valid_i && in_ready_i) begin
        blk = {plain_high_i, plain_low_i};
        if (cbc_q) blk ^= message_start_i ? iv_q : last_cipher;
        last_cipher = encrypt_block(blk);
        cipher_q.push_back(last_cipher);
      end
      if (out_valid_i && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, cipher_high_i, cipher_low_i);
          bad++;
        end else begin
          want = cipher_q.pop_front();
          if (want[127:64] !== cipher_high_i) begin
            $display("%0t: cipher_high expected %h got %h", $time, want[127:64], cipher_high_i);
            bad++;
          end
          if (want[63:0] !== cipher_low_i) begin
            $display("%0t: cipher_low expected %h got %h", $time, want[63:0], cipher_low_i);
            bad++;
          end
        end
      end
      if (bad != 0) errors_o <= errors_o + bad;
    end
  end
endmodule

/* tb/sv/tb.sv */
// Testbench top: stimulus, config phases, flow control and verdict for the AES core
`timescale 1ns / 1ps
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] plain_hi = '0;
  logic [63:0] plain_lo = '0;
  logic        msg_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] cipher_hi, cipher_lo;
  int          errors, pending;
  int          blocks_sent = 0;
  // no_gaps: both sides run flat out; long_stall: receiver holds off once
  bit          no_gaps = 1'b0;
  bit          long_stall = 1'b0;

  always #2 clk = ~clk;

  aes_block_encrypt_ecb_cbc_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .plain_high_i(plain_hi), .plain_low_i(plain_lo), .message_start_i(msg_start),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .cipher_high_o(cipher_hi), .cipher_low_o(cipher_lo)
  );

  aes_block_encrypt_ecb_cbc_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .plain_high_i(plain_hi), .plain_low_i(plain_lo), .message_start_i(msg_start),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .cipher_high_i(cipher_hi), .cipher_low_i(cipher_lo),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one block; valid is only dropped when a gap is drawn, so a
  // back-to-back transaction never sees a lower-then-raise in one step.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic ms);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    plain_hi  <= hi;
    plain_lo  <= lo;
    msg_start <= ms;
    blocks_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain the pipe, then write all eight registers back to back.
  task automatic program_core(input logic [1:0] ksize, input logic cbc,
                              input logic [63:0] k0, k1, k2, k3, iv_hi, iv_lo);
    logic [63:0] vals [8];
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (70) @(posedge clk);
    vals = '{k0, k1, k2, k3, 64'(ksize), 64'(cbc), iv_hi, iv_lo};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= aesbe_pkg::reg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: per transaction, hold off for a gap drawn as in send_block, or a long stretch once.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (long_stall) begin
        hold = 400;
        long_stall = 1'b0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [1:0] ksz;
    logic       cbc;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state (all-zero 128-bit key, ECB), field extremes,
    // message_start ignored in ECB.
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b1);
    send_block(64'h8000_0000_0000_0000, 64'h1, 1'b0);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);

    // ECB result chains into CBC when the next block has no message start.
    program_core(2'd0, 1'b1, '1, '1, '1, '1, '1, '1);
    send_block('0, '0, 1'b0);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    send_block('1, '0, 1'b0);

    // 192-bit key, CBC, zero IV.
    program_core(2'd1, 1'b1, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                 64'h1011_1213_1415_1617, '1, '0, '0);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1);
    send_block('1, '1, 1'b0);
    send_block('0, '0, 1'b0);

    // Key size code 3 behaves as 256-bit.
    program_core(2'd3, 1'b0, '1, '0, '1, '0, '0, '0);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);
    program_core(2'd2, 1'b0, '1, '0, '1, '0, '0, '0);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b0);

    // Random phases across every key size and both modes; each CBC phase
    // follows an ECB one and may open without a message start.
    for (int p = 0; p < 8; p++) begin
      ksz = 2'(p % 4);
      cbc = p[0];
      program_core(ksz, cbc, rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      no_gaps = (p == 2);
      if (p == 5) long_stall = 1'b1;
      for (int n = 0; n < 250; n++)
        send_block(rand64(), rand64(), $urandom_range(0, 7) == 0);
      no_gaps = 1'b0;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("Ran %0d blocks over 128/192/256-bit keys and key size code 3,", blocks_sent);
    $display("in ECB and CBC with IV starts, chained blocks and mode switches.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+src
src/aesbe_pkg.sv
src/aesbe_key_sched.sv
src/aes_block_encrypt_ecb_cbc_core.sv
tb/sv/aes_block_encrypt_ecb_cbc_checker.sv
tb/sv/tb.sv
